// ----- hdl/dcdf_pkg.sv -----
// Shared constants and controller/datapath interface types for the dilated FIR core.
package dcdf_pkg;

	localparam int MAX_TAPS_DEF      = 16;
	localparam int HISTORY_DEPTH_DEF = 256;

	localparam int VALUE_W = 16;
	localparam int TAPIDX_W = 4;
	localparam int CFG_W   = 5;
	localparam int CFGIDX_W = 1;
	localparam int ACC_W   = 40;
	localparam int PROD_W  = 32;
	localparam int NTAPS_W = 7;

	localparam logic [CFGIDX_W-1:0] REG_DILATION = 1'd0;
	localparam logic [CFGIDX_W-1:0] REG_TAPS     = 1'd1;

	localparam logic OP_WEIGHT = 1'b0;
	localparam logic OP_SAMPLE = 1'b1;

	typedef struct packed {
		logic wr_weight; // write the tap store from the input transaction
		logic push;      // store sample, update ring, clear accumulator
		logic issue;     // read one tap and its delayed sample
		logic finish;    // move accumulator into output register
	} dcdf_cmd_t;

	typedef struct packed {
		logic last_issue; // current tap is the last one in use
		logic ntaps_zero;
		logic out_full;
	} dcdf_sts_t;

endpackage

// ----- hdl/dcdf_ctrl.sv -----
// Sequencer for weight loads and the per-sample tap loop.
module dcdf_ctrl import dcdf_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	input  logic      in_op,
	output logic      in_ready,
	output dcdf_cmd_t cmd,
	input  dcdf_sts_t sts
);

	localparam logic [1:0] S_IDLE   = 2'd0;
	localparam logic [1:0] S_ISSUE  = 2'd1;
	localparam logic [1:0] S_DRAIN  = 2'd2;
	localparam logic [1:0] S_FINISH = 2'd3;

	logic [1:0] state_q, state_d;
	logic       drain_q, drain_d;
	logic       accept;

	assign in_ready = (state_q == S_IDLE);
	assign accept   = in_valid && in_ready;

	always_comb begin
		state_d       = state_q;
		drain_d       = drain_q;
		cmd           = '0;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					if (in_op == OP_WEIGHT) begin
						cmd.wr_weight = 1'b1;
					end else begin
						cmd.push = 1'b1;
						drain_d  = 1'b0;
						state_d  = sts.ntaps_zero ? S_DRAIN : S_ISSUE;
					end
				end
			end
			S_ISSUE: begin
				cmd.issue = 1'b1;
				if (sts.last_issue) begin
					drain_d = 1'b0;
					state_d = S_DRAIN;
				end
			end
			S_DRAIN: begin
				// wait for the read and multiply stages to empty
				drain_d = 1'b1;
				if (drain_q) begin
					state_d = S_FINISH;
				end
			end
			S_FINISH: begin
				if (!sts.out_full) begin
					cmd.finish = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			drain_q <= 1'b0;
		end else begin
			state_q <= state_d;
			drain_q <= drain_d;
		end
	end

endmodule

// ----- hdl/dcdf_datapath.sv -----
// Tap store, sample history ring, address generation, MAC pipeline and output register.
module dcdf_datapath import dcdf_pkg::*; #(
	parameter int MAX_TAPS      = MAX_TAPS_DEF,
	parameter int HISTORY_DEPTH = HISTORY_DEPTH_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [CFGIDX_W-1:0]        cfg_index,
	input  logic [CFG_W-1:0]           cfg_data,
	input  logic [TAPIDX_W-1:0]        in_tap_index,
	input  logic signed [VALUE_W-1:0]  in_value,
	input  logic                       in_start,
	input  dcdf_cmd_t                  cmd,
	output dcdf_sts_t                  sts,
	output logic                       out_valid,
	output logic [ACC_W-1:0]           out_data,
	input  logic                       out_ready
);

	localparam int TAP_W = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
	localparam int PW    = $clog2(HISTORY_DEPTH);
	localparam int CNW   = $clog2(HISTORY_DEPTH + 1);
	localparam int DLW   = $clog2(MAX_TAPS * 32);
	localparam int CMPW  = (DLW > CNW) ? DLW : CNW;

	logic signed [VALUE_W-1:0] tap_mem [MAX_TAPS];
	logic signed [VALUE_W-1:0] hist_mem [HISTORY_DEPTH];

	logic [CFG_W-1:0]        dilation_q, taps_q;
	logic [PW-1:0]           wpos_q, newest_q;
	logic [CNW-1:0]          cnt_q;
	logic [TAP_W-1:0]        k_q;
	logic [DLW-1:0]          delay_q;
	logic                    v_s1, v_s2;
	logic signed [VALUE_W-1:0] tw_s1, hs_s1;
	logic signed [PROD_W-1:0]  prod_s2;
	logic signed [ACC_W-1:0]   acc_q;
	logic [ACC_W-1:0]        out_data_q;
	logic                    out_valid_q;

	logic [NTAPS_W-1:0]      ntaps;
	logic [NTAPS_W-1:0]      tidx_w;
	logic [PW-1:0]           dly_p, slot;
	logic                    in_range;

	// clamp taps in use to the store depth
	always_comb begin
		ntaps = NTAPS_W'(taps_q);
		if (ntaps > NTAPS_W'(MAX_TAPS)) begin
			ntaps = NTAPS_W'(MAX_TAPS);
		end
	end

	assign tidx_w   = NTAPS_W'(in_tap_index);
	assign in_range = (CMPW'(delay_q) < CMPW'(cnt_q));
	assign dly_p    = PW'(delay_q);

	// ring slot of newest minus delay; only meaningful when in range
	always_comb begin
		if (newest_q >= dly_p) begin
			slot = newest_q - dly_p;
		end else begin
			slot = PW'((PW + 1)'(newest_q) + (PW + 1)'(HISTORY_DEPTH) - (PW + 1)'(dly_p));
		end
	end

	assign sts.last_issue = ((NTAPS_W'(k_q) + NTAPS_W'(1)) == ntaps);
	assign sts.ntaps_zero = (ntaps == '0);
	assign sts.out_full   = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dilation_q <= CFG_W'(1);
			taps_q     <= CFG_W'(1);
		end else if (cfg_we) begin
			case (cfg_index)
				REG_DILATION: dilation_q <= cfg_data;
				REG_TAPS:     taps_q     <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.wr_weight && (tidx_w < NTAPS_W'(MAX_TAPS))) begin
			tap_mem[tidx_w[TAP_W-1:0]] <= in_value;
		end
		tw_s1 <= tap_mem[k_q];
	end

	always_ff @(posedge clk) begin
		if (cmd.push) begin
			hist_mem[wpos_q] <= in_value;
		end
		hs_s1 <= hist_mem[slot];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wpos_q  <= '0;
			cnt_q   <= '0;
			k_q     <= '0;
			delay_q <= '0;
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
		end else begin
			v_s1 <= cmd.issue && in_range;
			v_s2 <= v_s1;
			if (cmd.push) begin
				wpos_q  <= (wpos_q == PW'(HISTORY_DEPTH - 1)) ? '0 : wpos_q + PW'(1);
				if (in_start) begin
					cnt_q <= CNW'(1);
				end else if (cnt_q < CNW'(HISTORY_DEPTH)) begin
					cnt_q <= cnt_q + CNW'(1);
				end
				k_q     <= '0;
				delay_q <= '0;
			end else if (cmd.issue) begin
				k_q     <= k_q + TAP_W'(1);
				delay_q <= delay_q + DLW'(dilation_q);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.push) begin
			newest_q <= wpos_q;
		end
		prod_s2 <= tw_s1 * hs_s1;
		if (cmd.push) begin
			acc_q <= '0;
		end else if (v_s2) begin
			acc_q <= acc_q + ACC_W'(prod_s2);
		end
		if (cmd.finish) begin
			out_data_q <= acc_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.finish) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule

// ----- hdl/dilated_causal_depthwise_fir_core.sv -----
// A sample is pushed into the history, the tap loop runs over ntaps taps (ntaps =
// taps_in_use clamped to MAX_TAPS), the read and multiply stages drain, and the sum
// enters the output register once free. Input is taken only while idle, weights one
// per cycle; the single tap loop does one history read and one MAC per cycle.
// Reset: arst_n clears control, counters, ring position and configuration; the tap
// store and sample history are not cleared and hold stale data until written.
module dilated_causal_depthwise_fir_core import dcdf_pkg::*; #(
	parameter int MAX_TAPS      = MAX_TAPS_DEF,
	parameter int HISTORY_DEPTH = HISTORY_DEPTH_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [CFGIDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]    cfg_data,
	input  logic                s_axis_tvalid,
	output logic                s_axis_tready,
	input  logic [23:0]         s_axis_tdata,  // tap_index[3:0], value[19:4], zero pad
	input  logic [1:0]          s_axis_tuser,  // operation[0], channel_start[1]
	output logic                m_axis_tvalid,
	input  logic                m_axis_tready,
	output logic [39:0]         m_axis_tdata   // filtered_value[39:0]
);

	dcdf_cmd_t cmd;
	dcdf_sts_t sts;

	dcdf_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_op    (s_axis_tuser[0]),
		.in_ready (s_axis_tready),
		.cmd      (cmd),
		.sts      (sts)
	);

	dcdf_datapath #(
		.MAX_TAPS      (MAX_TAPS),
		.HISTORY_DEPTH (HISTORY_DEPTH)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_tap_index (s_axis_tdata[3:0]),
		.in_value     (s_axis_tdata[19:4]),
		.in_start     (s_axis_tuser[1]),
		.cmd          (cmd),
		.sts          (sts),
		.out_valid    (m_axis_tvalid),
		.out_data     (m_axis_tdata),
		.out_ready    (m_axis_tready)
	);

	// no new transaction is taken while the tap loop runs
	a_issue_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.issue |-> !s_axis_tready)
		else $error("tap issue while input ready");

	// result never overwrites one still waiting
	a_finish_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |-> !m_axis_tvalid)
		else $error("output overwritten");

	// a push only on an accepted sample transaction
	a_push_accept: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.push |-> (s_axis_tvalid && s_axis_tready && s_axis_tuser[0] == OP_SAMPLE))
		else $error("push without sample transaction");

	// finishing always raises the output valid next cycle
	a_finish_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |=> m_axis_tvalid)
		else $error("result lost after finish");

endmodule
